FILE: hw/rtl/dtmf_pkg.sv
// ----------------------------------------------------------------------------
// dtmf_pkg: shared types and constants of the dilated-tap MIMO FIR
// Holds the controller states, the command and status words, register codes
// and the clamp helpers for the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtmf_pkg;

    // Counter width covers counts up to 127
    localparam int CNT_W      = 7;
    localparam int LAG_W      = 2 * CNT_W;
    localparam int TIME_W     = 17;
    localparam int TIDX_W     = 16;
    localparam int CH_W       = 3;
    localparam int SMP_W      = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Request kinds
    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_CHANNELS   = 3'd0,
        CFG_OUT_CHANNELS  = 3'd1,
        CFG_TAP_COUNT     = 3'd2,
        CFG_TAP_SPACING   = 3'd3,
        CFG_OUTPUT_LENGTH = 3'd4
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             issue;
        logic             first;
        logic             last;
        logic             tap_end;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] m;
        logic [CNT_W-1:0] j;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fire;
        logic spm_ok;
        logic pipe_busy;
        logic out_busy;
    } t_dp_status;

    // Clamp a count register to 1..hi
    function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] v,
                                                     input int unsigned hi);
        logic [CNT_W-1:0] r;
        if (v == 4'd0) begin
            r = CNT_W'(1);
        end else if (32'(v) > hi) begin
            r = CNT_W'(hi);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Clamp a register to 0..hi
    function automatic logic [CNT_W-1:0] clamp_upper(input logic [3:0] v,
                                                     input int unsigned hi);
        logic [CNT_W-1:0] r;
        if (32'(v) > hi) begin
            r = CNT_W'(hi);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/dtmf_req_if.sv
// ----------------------------------------------------------------------------
// dtmf_req_if: request channel
// Valid/ready channel that carries weight writes and input samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtmf_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [2:0]         in_channel;
    logic [2:0]         out_channel_sel;
    logic [2:0]         tap_index;
    logic signed [15:0] value;
    logic               trial_start;

    modport source (
        output valid, req_type, in_channel, out_channel_sel, tap_index, value,
               trial_start,
        input  ready
    );
    modport sink (
        input  valid, req_type, in_channel, out_channel_sel, tap_index, value,
               trial_start,
        output ready
    );
endinterface

FILE: hw/rtl/dtmf_rsp_if.sv
// ----------------------------------------------------------------------------
// dtmf_rsp_if: result channel
// Valid/ready channel that carries one filter output word per channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtmf_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_channel;
    logic [15:0]        time_index;
    logic signed [39:0] acc_out;
    logic               last;

    modport source (
        output valid, out_channel, time_index, acc_out, last,
        input  ready
    );
    modport sink (
        input  valid, out_channel, time_index, acc_out, last,
        output ready
    );
endinterface

FILE: hw/rtl/dtmf_ctrl.sv
// ----------------------------------------------------------------------------
// dtmf_ctrl: sequencer of the filter
// Walks output channel, tap and input channel counters and issues one
// multiply-accumulate per cycle to the datapath in the issue state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_ctrl import dtmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_nin,
    input  logic [CNT_W-1:0] i_nout,
    input  logic [CNT_W-1:0] i_ntap,
    input  t_dp_status       i_status,
    output t_ctl_cmd         o_cmd,
    output logic             o_in_ready
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_m, n_m;
    logic             m_end;
    logic             j_end;

    assign m_end = (r_m == i_nin - CNT_W'(1));
    assign j_end = (r_j == i_ntap - CNT_W'(1));

    // State and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_j     <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_j     <= n_j;
            r_m     <= n_m;
        end
    end

    // Next state, counters and commands
    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_j           = r_j;
        n_m           = r_m;
        o_in_ready    = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.first   = (r_j == '0) && (r_m == '0);
        o_cmd.last    = m_end && j_end;
        o_cmd.tap_end = m_end;
        o_cmd.n       = r_n;
        o_cmd.m       = r_m;
        o_cmd.j       = r_j;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_status.fire) begin
                    n_state = ST_WAIT;
                    n_n     = '0;
                    n_j     = '0;
                    n_m     = '0;
                end
            end
            ST_WAIT: begin
                // hold until spacing is reduced and the output word is free
                if (i_status.spm_ok && !i_status.out_busy) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (m_end) begin
                    n_m = '0;
                    if (j_end) begin
                        n_j     = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_j = r_j + CNT_W'(1);
                    end
                end else begin
                    n_m = r_m + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    if (r_n == i_nout - CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_n     = r_n + CNT_W'(1);
                        n_state = ST_WAIT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dtmf_datapath.sv
// ----------------------------------------------------------------------------
// dtmf_datapath: stores, time count and MAC pipeline
// Holds the weight store and sample history, tracks the time step, and runs
// a read / multiply / saturating-accumulate pipeline into the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_datapath import dtmf_pkg::*; #(
    parameter int MAX_IN_CHANNELS  = 8,
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int MAX_TAPS         = 8,
    parameter int HISTORY_DEPTH    = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CNT_W-1:0]        i_nin,
    input  logic [CNT_W-1:0]        i_ntap,
    input  logic [CNT_W-1:0]        i_sp,
    input  logic [TIDX_W-1:0]       i_olen,
    input  logic                    i_accept,
    input  logic                    i_req_type,
    input  logic [CH_W-1:0]         i_in_channel,
    input  logic [CH_W-1:0]         i_out_channel_sel,
    input  logic [CH_W-1:0]         i_tap_index,
    input  logic signed [SMP_W-1:0] i_value,
    input  logic                    i_trial_start,
    input  t_ctl_cmd                i_cmd,
    output t_dp_status              o_status,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CH_W-1:0]         o_out_channel,
    output logic [TIDX_W-1:0]       o_time_index,
    output logic signed [ACC_W-1:0] o_acc_out,
    output logic                    o_last
);

    localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int HDEPTH = HISTORY_DEPTH * MAX_IN_CHANNELS;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int RW     = $clog2(HISTORY_DEPTH);

    logic [SMP_W-1:0] r_wmem [WDEPTH];
    logic [SMP_W-1:0] r_hmem [HDEPTH];

    logic [TIME_W-1:0] r_time;
    logic [RW-1:0]     r_row;
    logic [RW-1:0]     r_base;
    logic [RW-1:0]     r_tap_row;
    logic [RW-1:0]     row_next;
    logic [CNT_W-1:0]  r_spm;
    logic [TIDX_W-1:0] r_t;

    logic              is_sample;
    logic              wr_ok;
    logic              smp_ok;
    logic              last_ch;
    logic [TIME_W-1:0] s_cur;
    logic [RW-1:0]     row_cur;
    logic [LAG_W-1:0]  lag;
    logic [TIME_W-1:0] t_full;
    logic              fire;
    logic [WAW-1:0]    w_wr_addr;
    logic [HAW-1:0]    h_wr_addr;
    logic [WAW-1:0]    w_rd_addr;
    logic [HAW-1:0]    h_rd_addr;

    logic                     r_va, r_vb;
    logic                     r_first_a, r_first_b;
    logic                     r_last_a, r_last_b;
    logic [CNT_W-1:0]         r_n_a, r_n_b;
    logic signed [SMP_W-1:0]  r_x, r_w;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  acc_sat;

    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_ch;
    logic [TIDX_W-1:0]        r_out_t;
    logic signed [ACC_W-1:0]  r_out_acc;
    logic                     r_out_last;

    // Decode the request
    assign is_sample = (i_req_type == REQ_SAMPLE);
    assign wr_ok     = !is_sample
                    && (32'(i_out_channel_sel) < MAX_OUT_CHANNELS)
                    && (32'(i_in_channel) < MAX_IN_CHANNELS)
                    && (32'(i_tap_index) < MAX_TAPS);
    assign smp_ok    = is_sample && (CNT_W'(i_in_channel) < i_nin);
    assign last_ch   = (CNT_W'(i_in_channel) == i_nin - CNT_W'(1));
    assign s_cur     = i_trial_start ? '0 : r_time;
    assign row_cur   = i_trial_start ? '0 : r_row;

    // Step start test: last channel of an accepted sample, s >= lag and t < output_length
    assign lag    = LAG_W'(i_sp) * LAG_W'(i_ntap - CNT_W'(1));
    assign t_full = s_cur - TIME_W'(lag);
    assign fire   = i_accept && smp_ok && last_ch
                 && (s_cur >= TIME_W'(lag))
                 && (t_full < TIME_W'(i_olen));

    assign w_wr_addr = WAW'((32'(i_out_channel_sel) * MAX_IN_CHANNELS
                             + 32'(i_in_channel)) * MAX_TAPS + 32'(i_tap_index));
    assign h_wr_addr = HAW'(32'(row_cur) * MAX_IN_CHANNELS + 32'(i_in_channel));
    assign w_rd_addr = WAW'((32'(i_cmd.n) * MAX_IN_CHANNELS + 32'(i_cmd.m))
                            * MAX_TAPS + 32'(i_cmd.j));
    assign h_rd_addr = HAW'(32'(r_tap_row) * MAX_IN_CHANNELS + 32'(i_cmd.m));

    // Step back one tap, wrapping around the history
    assign row_next = (32'(r_tap_row) >= 32'(r_spm))
                    ? RW'(32'(r_tap_row) - 32'(r_spm))
                    : RW'(32'(r_tap_row) + HISTORY_DEPTH - 32'(r_spm));

    // Weight store
    always_ff @(posedge i_clk) begin
        if (i_accept && wr_ok) begin
            r_wmem[w_wr_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_w <= r_wmem[w_rd_addr];
        end
    end

    // Sample history
    always_ff @(posedge i_clk) begin
        if (i_accept && smp_ok) begin
            r_hmem[h_wr_addr] <= i_value;
        end
        if (i_cmd.issue) begin
            r_x <= r_hmem[h_rd_addr];
        end
    end

    // Time count and history row; advance at the last channel of a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_row  <= '0;
        end else if (i_accept && smp_ok) begin
            if (last_ch && (s_cur != TIME_MAX)) begin
                r_time <= s_cur + TIME_W'(1);
                r_row  <= (32'(row_cur) == HISTORY_DEPTH - 1) ? '0
                                                              : row_cur + RW'(1);
            end else begin
                r_time <= s_cur;
                r_row  <= row_cur;
            end
        end
    end

    // Step context: base row, time tag, spacing reduced below the depth
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_base    <= row_cur;
            r_tap_row <= row_cur;
            r_t       <= t_full[TIDX_W-1:0];
            r_spm     <= i_sp;
        end else begin
            if (32'(r_spm) >= HISTORY_DEPTH) begin
                r_spm <= r_spm - CNT_W'(HISTORY_DEPTH);
            end
            if (i_cmd.issue) begin
                if (i_cmd.last) begin
                    r_tap_row <= r_base;
                end else if (i_cmd.tap_end) begin
                    r_tap_row <= row_next;
                end
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_cmd.issue;
            r_vb <= r_va;
        end
    end

    // Carry tags down the pipeline and multiply
    always_ff @(posedge i_clk) begin
        r_first_a <= i_cmd.first;
        r_last_a  <= i_cmd.last;
        r_n_a     <= i_cmd.n;
        r_first_b <= r_first_a;
        r_last_b  <= r_last_a;
        r_n_b     <= r_n_a;
        r_prod    <= r_x * r_w;
    end

    // Saturating accumulate
    always_comb begin
        sum = (r_first_b ? '0 : {r_acc[ACC_W-1], r_acc})
            + {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = sum[ACC_W-1:0];
        end
    end

    // Capture the output word with its own time tag
    always_ff @(posedge i_clk) begin
        if (r_vb) begin
            r_acc <= acc_sat;
        end
        if (r_vb && r_last_b) begin
            r_out_ch   <= r_n_b[CH_W-1:0];
            r_out_t    <= r_t;
            r_out_acc  <= acc_sat;
            r_out_last <= (r_n_b == i_cmd.n) && 1'b0;
        end
    end

    // Output word valid; drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_vb && r_last_b) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_time_index  = r_out_t;
    assign o_acc_out     = r_out_acc;
    assign o_last        = r_out_last;

    assign o_status.fire      = fire;
    assign o_status.spm_ok    = (32'(r_spm) < HISTORY_DEPTH);
    assign o_status.pipe_busy = r_va || r_vb;
    assign o_status.out_busy  = r_out_valid;

endmodule

FILE: hw/rtl/dilated_tap_mimo_fir.sv
// ----------------------------------------------------------------------------
// dilated_tap_mimo_fir: multichannel FIR filter with dilated taps
// Weight words and non-final samples leave the input open. The last sample of a
// step that starts an output runs one MAC per cycle while issuing, waiting for a
// free output word and draining between output channels. Reset clears control and time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dilated_tap_mimo_fir import dtmf_pkg::*; #(
    parameter int MAX_IN_CHANNELS  = 8,
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int MAX_TAPS         = 8,
    parameter int MAX_SPACING      = 8,
    parameter int HISTORY_DEPTH    = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dtmf_req_if.sink              i_req,
    dtmf_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [3:0]        r_cfg_nin;
    logic [3:0]        r_cfg_nout;
    logic [3:0]        r_cfg_ntap;
    logic [3:0]        r_cfg_sp;
    logic [TIDX_W-1:0] r_cfg_olen;

    logic [CNT_W-1:0]  nin, nout, ntap, sp;
    logic              in_accept;
    logic              last_flag;
    t_ctl_cmd          cmd;
    t_dp_status        status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nin  <= 4'd1;
            r_cfg_nout <= 4'd1;
            r_cfg_ntap <= 4'd1;
            r_cfg_sp   <= 4'd1;
            r_cfg_olen <= TIDX_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_CHANNELS:   r_cfg_nin  <= i_cfg_data[3:0];
                CFG_OUT_CHANNELS:  r_cfg_nout <= i_cfg_data[3:0];
                CFG_TAP_COUNT:     r_cfg_ntap <= i_cfg_data[3:0];
                CFG_TAP_SPACING:   r_cfg_sp   <= i_cfg_data[3:0];
                CFG_OUTPUT_LENGTH: r_cfg_olen <= i_cfg_data[TIDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp to the supported ranges
    assign nin  = clamp_count(r_cfg_nin, MAX_IN_CHANNELS);
    assign nout = clamp_count(r_cfg_nout, MAX_OUT_CHANNELS);
    assign ntap = clamp_count(r_cfg_ntap, MAX_TAPS);
    assign sp   = clamp_upper(r_cfg_sp, MAX_SPACING);

    assign in_accept = i_req.valid && i_req.ready;

    dtmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nin      (nin),
        .i_nout     (nout),
        .i_ntap     (ntap),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (i_req.ready)
    );

    dtmf_datapath #(
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
        .MAX_TAPS         (MAX_TAPS),
        .HISTORY_DEPTH    (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_nin             (nin),
        .i_ntap            (ntap),
        .i_sp              (sp),
        .i_olen            (r_cfg_olen),
        .i_accept          (in_accept),
        .i_req_type        (i_req.req_type),
        .i_in_channel      (i_req.in_channel),
        .i_out_channel_sel (i_req.out_channel_sel),
        .i_tap_index       (i_req.tap_index),
        .i_value           (i_req.value),
        .i_trial_start     (i_req.trial_start),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_valid           (o_rsp.valid),
        .i_ready           (o_rsp.ready),
        .o_out_channel     (o_rsp.out_channel),
        .o_time_index      (o_rsp.time_index),
        .o_acc_out         (o_rsp.acc_out),
        .o_last            (last_flag)
    );

    // Final channel flag follows the channel index of the word
    assign o_rsp.last = last_flag
                     || (CNT_W'(o_rsp.out_channel) == nout - CNT_W'(1));

    // Inputs are taken only with the MAC pipeline empty
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !status.pipe_busy)
        else $error("input taken while MAC pipeline busy");

    // A channel sweep starts only with the output word free
    a_sweep_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.issue && cmd.first) |-> !o_rsp.valid)
        else $error("sweep started over a pending output word");

    // A step start closes the input side
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fire |=> !i_req.ready)
        else $error("input still open after step start");

endmodule

FILE: dv/dtmf_checker.sv
// ----------------------------------------------------------------------------
// dtmf_checker: result predictor and scoreboard for dilated_tap_mimo_fir
// Watches the request, result and configuration ports. It keeps its own
// weight store, sample history and time count, and computes the expected
// output words for each accepted request. Each result word is compared with
// the oldest expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtmf_checker import dtmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dtmf_req_if                   i_req,
    dtmf_rsp_if                   i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int N_IN   = 8;
    localparam int N_OUT  = 8;
    localparam int N_TAP  = 8;
    localparam int SP_MAX = 8;
    localparam int H_DEPTH = 64;
    localparam int T_SAT  = 131071;

    typedef struct {
        logic [2:0]         ch;
        logic [15:0]        tidx;
        logic signed [39:0] acc;
        logic               last;
    } t_fir_word;

    t_fir_word        fir_q[$];
    logic [3:0]       r_in, r_out, r_taps, r_sp;
    logic [15:0]      r_len;
    logic signed [15:0] coef_mem [N_OUT*N_IN*N_TAP];
    logic signed [15:0] hist_mem [H_DEPTH*N_IN];
    int               step_time;

    assign o_pending = fir_q.size();

    initial o_fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic int clamp_cnt(input logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > 4'd8) return 8;
        return int'(v);
    endfunction

    // Apply one accepted request and queue the words it produces
    task automatic predict_fir(input logic rt, input logic [2:0] ch,
                               input logic [2:0] osel, input logic [2:0] tap,
                               input logic signed [15:0] val, input logic ts);
        int nin, nout, ntap, sp, lag, s, row;
        logic signed [47:0] acc, prod;
        t_fir_word w;
        nin  = clamp_cnt(r_in);
        nout = clamp_cnt(r_out);
        ntap = clamp_cnt(r_taps);
        sp   = (r_sp > 4'd8) ? SP_MAX : int'(r_sp);
        if (rt == REQ_WEIGHT) begin
            coef_mem[(int'(osel) * N_IN + int'(ch)) * N_TAP + int'(tap)] = val;
            return;
        end
        // drop samples beyond the active channel count, trial start too
        if (int'(ch) >= nin) return;
        if (ts) step_time = 0;
        s = step_time;
        hist_mem[(s % H_DEPTH) * N_IN + int'(ch)] = val;
        if (int'(ch) != nin - 1) return;
        lag = sp * (ntap - 1);
        if (s >= lag && (s - lag) < int'(r_len)) begin
            for (int n = 0; n < nout; n++) begin
                acc = '0;
                for (int j = 0; j < ntap; j++) begin
                    row = ((s - j * sp) % H_DEPTH) * N_IN;
                    for (int m = 0; m < nin; m++) begin
                        prod = hist_mem[row + m] * coef_mem[(n * N_IN + m) * N_TAP + j];
                        acc = acc + prod;
                        // saturate the running sum after every add
                        if (acc > 48'sd549755813887) acc = 48'sd549755813887;
                        if (acc < -48'sd549755813888) acc = -48'sd549755813888;
                    end
                end
                w.ch   = n[2:0];
                w.tidx = 16'(s - lag);
                w.acc  = acc[39:0];
                w.last = (n == nout - 1);
                fir_q.push_back(w);
            end
        end
        if (step_time < T_SAT) step_time++;
    endtask

    always @(posedge i_clk) begin
        t_fir_word e;
        if (!i_rst_n) begin
            r_in      = 4'd1;
            r_out     = 4'd1;
            r_taps    = 4'd1;
            r_sp      = 4'd1;
            r_len     = 16'd1;
            step_time = 0;
            fir_q.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_IN_CHANNELS:   r_in   = i_cfg_data[3:0];
                    CFG_OUT_CHANNELS:  r_out  = i_cfg_data[3:0];
                    CFG_TAP_COUNT:     r_taps = i_cfg_data[3:0];
                    CFG_TAP_SPACING:   r_sp   = i_cfg_data[3:0];
                    CFG_OUTPUT_LENGTH: r_len  = i_cfg_data;
                    default: ;
                endcase
            end
            // compare result words against the oldest expectation
            if (i_rsp.valid && i_rsp.ready) begin
                if (fir_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word ch=%0d t=%0d",
                                              i_rsp.out_channel, i_rsp.time_index));
                end else begin
                    e = fir_q.pop_front();
                    if (i_rsp.out_channel !== e.ch)
                        report_mismatch($sformatf("out_channel %0d, want %0d",
                                                  i_rsp.out_channel, e.ch));
                    if (i_rsp.time_index !== e.tidx)
                        report_mismatch($sformatf("time_index %0d, want %0d",
                                                  i_rsp.time_index, e.tidx));
                    if (i_rsp.acc_out !== e.acc)
                        report_mismatch($sformatf("acc_out %0d, want %0d (ch %0d t %0d)",
                                                  i_rsp.acc_out, e.acc, e.ch, e.tidx));
                    if (i_rsp.last !== e.last)
                        report_mismatch($sformatf("last %0b, want %0b (ch %0d t %0d)",
                                                  i_rsp.last, e.last, e.ch, e.tidx));
                end
            end
            // predict accepted requests
            if (i_req.valid && i_req.ready)
                predict_fir(i_req.req_type, i_req.in_channel, i_req.out_channel_sel,
                            i_req.tap_index, i_req.value, i_req.trial_start);
        end
    end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for dilated_tap_mimo_fir
// Drives weight writes and sample steps in bursts over several register
// settings, stalls the result side on a changing pattern, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import dtmf_pkg::*;

    localparam int SETTLE = 700;   // settling margin covering the longest step

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending;
    int                    fail_count;

    dtmf_req_if req_if();
    dtmf_rsp_if rsp_if();

    dilated_tap_mimo_fir u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dtmf_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side on a pattern, picked at random from four modes, that changes periodically
    int stall_mode = 0;
    int stall_cnt  = 0;
    initial rsp_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt  = 64;
        end
        stall_cnt--;
        case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= (stall_cnt % 8) < 5;
        endcase
    end

    // Hard stop for a hung run
    initial begin
        #12_000_000;
        $display("dilated_tap_mimo_fir verification failed");
        $finish;
    end

    int   burst_left = 0;
    int   word_cnt = 0;
    bit   coef_set [512];
    int   cur_in = 1, cur_out = 1, cur_taps = 1;

    initial begin
        req_if.valid           = 1'b0;
        req_if.req_type        = REQ_WEIGHT;
        req_if.in_channel      = '0;
        req_if.out_channel_sel = '0;
        req_if.tap_index       = '0;
        req_if.value           = '0;
        req_if.trial_start     = 1'b0;
    end

    // Send one word, with random gaps between bursts
    task automatic send_word(input logic rt, input logic [2:0] ch, input logic [2:0] osel,
                             input logic [2:0] tap, input logic [15:0] v, input logic ts);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        req_if.valid           <= 1'b1;
        req_if.req_type        <= rt;
        req_if.in_channel      <= ch;
        req_if.out_channel_sel <= osel;
        req_if.tap_index       <= tap;
        req_if.value           <= v;
        req_if.trial_start     <= ts;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
        word_cnt++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int clamp_cnt(input int v);
        if (v == 0) return 1;
        return (v > 8) ? 8 : v;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Wait until every expected word is back and the block has settled
    task automatic drain_block();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Fill every weight the current setting reads that is still unwritten
    task automatic load_weights();
        for (int n = 0; n < cur_out; n++)
            for (int m = 0; m < cur_in; m++)
                for (int j = 0; j < cur_taps; j++)
                    if (!coef_set[n * 64 + m * 8 + j]) begin
                        send_word(REQ_WEIGHT, m[2:0], n[2:0], j[2:0], pick_value(), 1'b0);
                        coef_set[n * 64 + m * 8 + j] = 1'b1;
                    end
    endtask

    // Send whole time steps in channel order, mixed with noise and cut steps
    task automatic run_steps(input int nsteps);
        logic [8:0] a;
        int k;
        for (int s = 0; s < nsteps; s++) begin
            if (cur_in < 8 && $urandom_range(0, 7) == 0)
                send_word(REQ_SAMPLE, 3'($urandom_range(cur_in, 7)), 3'($urandom),
                          3'($urandom), pick_value(), 1'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                a = 9'($urandom);
                send_word(REQ_WEIGHT, a[5:3], a[8:6], a[2:0], pick_value(), 1'b0);
                coef_set[a] = 1'b1;
            end
            // cut step: the following full step rewrites the same row
            if (cur_in > 1 && s > 0 && $urandom_range(0, 11) == 0) begin
                k = $urandom_range(0, cur_in - 2);
                for (int m = 0; m <= k; m++)
                    send_word(REQ_SAMPLE, m[2:0], 3'($urandom), 3'($urandom),
                              pick_value(), 1'b0);
            end
            for (int m = 0; m < cur_in; m++)
                send_word(REQ_SAMPLE, m[2:0], 3'($urandom), 3'($urandom), pick_value(),
                          m == 0 && (s == 0 || $urandom_range(0, 39) == 0));
        end
    endtask

    task automatic run_phase(input int nin, input int nout, input int ntaps, input int sp,
                             input int len, input int nsteps);
        write_reg(CFG_IN_CHANNELS,   {12'($urandom), 4'(nin)});
        write_reg(CFG_OUT_CHANNELS,  {12'($urandom), 4'(nout)});
        write_reg(CFG_TAP_COUNT,     {12'($urandom), 4'(ntaps)});
        write_reg(CFG_TAP_SPACING,   {12'($urandom), 4'(sp)});
        write_reg(CFG_OUTPUT_LENGTH, 16'(len));
        cur_in   = clamp_cnt(nin);
        cur_out  = clamp_cnt(nout);
        cur_taps = clamp_cnt(ntaps);
        load_weights();
        run_steps(nsteps);
        drain_block();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: one channel, one tap, one output step per trial
        send_word(REQ_WEIGHT, 3'd0, 3'd0, 3'd0, 16'h8000, 1'b0);
        coef_set[0] = 1'b1;
        send_word(REQ_SAMPLE, 3'd0, 3'd7, 3'd7, 16'h8000, 1'b1);
        send_word(REQ_SAMPLE, 3'd0, 3'd0, 3'd0, 16'h7FFF, 1'b0);
        send_word(REQ_SAMPLE, 3'd5, 3'd0, 3'd0, 16'h1234, 1'b1);
        send_word(REQ_WEIGHT, 3'd0, 3'd0, 3'd0, 16'h7FFF, 1'b0);
        send_word(REQ_SAMPLE, 3'd0, 3'd0, 3'd0, 16'h8000, 1'b1);
        send_word(REQ_SAMPLE, 3'd0, 3'd0, 3'd0, 16'h7FFF, 1'b1);
        drain_block();

        // extremes: widest step, deepest lag, clamped registers, no output, short length
        run_phase(8, 8, 1, 0, 65535, 4);
        run_phase(2, 3, 8, 8, 65535, 62);
        run_phase(0, 15, 15, 15, 0, 3);
        run_phase(3, 2, 3, 2, 5, 12);

        // random settings, mostly small
        while (word_cnt < 420)
            run_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                      $urandom_range(0, 3),
                      ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(1, 20),
                      $urandom_range(8, 24));

        if (fail_count == 0 && pending == 0) begin
            $display("dilated_tap_mimo_fir verification clean");
        end else begin
            $display("dilated_tap_mimo_fir verification failed");
        end
        $finish;
    end

endmodule
